// ===== design/tftp_data_block_receiver_core_macros.svh =====
// assertion helpers for the core top level, the only file that asserts
`ifndef TFTP_DATA_BLOCK_RECEIVER_CORE_MACROS_SVH
`define TFTP_DATA_BLOCK_RECEIVER_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define TDBR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define TDBR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tdbr_pkg.sv =====
package tdbr_pkg;

  localparam logic [15:0] OPCODE_DATA     = 16'd3;
  localparam logic [2:0]  HDR_BYTES       = 3'd4;
  localparam logic [2:0]  HDR_LAST        = 3'd3;
  localparam logic [31:0] LOAD_BASE_RESET = 32'h3100_0000;
  localparam int          QUEUE_DEPTH     = 4;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_ACK   = 1'b1
  } result_kind_t;

  // one queued work item: an optional payload write and an optional ack
  typedef struct packed {
    logic        has_write;
    logic        has_ack;
    logic [31:0] offset;
    logic [7:0]  data;
    logic [15:0] block;
    logic [15:0] port;
    logic        done;
  } work_t;

endpackage

// ===== design/tdbr_channels.sv =====
interface tdbr_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        packet_end;
  logic [15:0] peer_port;

  modport source (output valid, payload_byte, packet_end, peer_port, input ready);
  modport sink (input valid, payload_byte, packet_end, peer_port, output ready);
endinterface

interface tdbr_result_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] write_address;
  logic [7:0]  write_data;
  logic [15:0] ack_block;
  logic [15:0] ack_port;
  logic        transfer_done;
  logic        last_of_run;

  modport source (
    output valid, result_kind, write_address, write_data, ack_block, ack_port,
           transfer_done, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, result_kind, write_address, write_data, ack_block, ack_port,
           transfer_done, last_of_run,
    output ready
  );
endinterface

// ===== design/tftp_data_block_receiver_core.sv =====
// path: a byte transfer is pushed into the work queue, then loaded into the output register
// throughput: one byte per cycle while the work queue has room; a byte that both writes and acks
//   needs two output transfers, absorbed by the four-entry work queue between parser and result stage
// reset: parser state cleared, expected block 1, load base 0x31000000, queue and
//   output register empty
`include "tftp_data_block_receiver_core_macros.svh"

module tftp_data_block_receiver_core
  import tdbr_pkg::*;
#(
  parameter int BLOCK_BYTES = 512
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write_en,
  input  logic [31:0]   cfg_write_data,
  tdbr_byte_if.sink     rx,
  tdbr_result_if.source results
);

  logic [31:0] load_base;
  work_t       push_item, head;
  logic        push, push_ready, head_valid, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_base <= LOAD_BASE_RESET;
    end else if (cfg_write_en) begin
      load_base <= cfg_write_data;
    end
  end

  tdbr_front #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .work      (push_item),
    .work_valid(push),
    .work_ready(push_ready)
  );

  tdbr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_item (push_item),
    .push      (push),
    .push_ready(push_ready),
    .head      (head),
    .head_valid(head_valid),
    .pop       (pop)
  );

  tdbr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .load_base (load_base),
    .head      (head),
    .head_valid(head_valid),
    .pop       (pop),
    .results   (results)
  );

  `TDBR_ASSERT_IMP(a_ack_ends_run, clk, rst, results.valid && results.result_kind == KIND_ACK, results.last_of_run, "ack result not marked last")
  `TDBR_ASSERT_NEXT(a_write_then_ack, clk, rst, results.valid && results.ready && results.result_kind == KIND_WRITE && !results.last_of_run, results.valid && results.result_kind == KIND_ACK, "write not followed by its ack")
  `TDBR_ASSERT_IMP(a_write_clean, clk, rst, results.valid && results.result_kind == KIND_WRITE, results.ack_block == 16'd0 && results.ack_port == 16'd0 && !results.transfer_done, "write result carries ack fields")

endmodule

// ===== design/tdbr_front.sv =====
module tdbr_front
  import tdbr_pkg::*;
#(
  parameter int BLOCK_BYTES = 512
) (
  input  logic       clk,
  input  logic       rst,
  tdbr_byte_if.sink  rx,
  output work_t      work,
  output logic       work_valid,
  input  logic       work_ready
);

  localparam int CW = $clog2(BLOCK_BYTES + 1);
  localparam logic [CW-1:0] BLOCK_LIMIT = CW'(BLOCK_BYTES);
  localparam logic [31:0]   BLOCK_MUL   = 32'(BLOCK_BYTES);

  logic [2:0]    header_index, header_index_next;
  logic [15:0]   opcode_seen, opcode_seen_next;
  logic [15:0]   block_seen, block_seen_next;
  logic [15:0]   expected_block, expected_block_next;
  logic [CW-1:0] payload_count, payload_count_next;
  logic [31:0]   block_offset;
  logic [15:0]   block_minus_one;

  logic accept, in_header, has_write, has_ack, done;

  assign accept   = rx.valid && rx.ready;
  assign rx.ready = work_ready;
  assign in_header = header_index < HDR_BYTES;

  always_comb begin
    header_index_next = header_index;
    opcode_seen_next  = opcode_seen;
    block_seen_next   = block_seen;
    if (in_header) begin
      header_index_next = header_index + 3'd1;
      if (header_index < 3'd2) begin
        opcode_seen_next = {opcode_seen[7:0], rx.payload_byte};
      end else begin
        block_seen_next = {block_seen[7:0], rx.payload_byte};
      end
    end
    has_write = !in_header && opcode_seen == OPCODE_DATA && block_seen == expected_block
                && payload_count < BLOCK_LIMIT;
    payload_count_next = payload_count + CW'(has_write);
    has_ack = rx.packet_end && header_index_next == HDR_BYTES
              && opcode_seen_next == OPCODE_DATA && block_seen_next == expected_block;
    done = payload_count_next < BLOCK_LIMIT;
    expected_block_next = expected_block;
    if (has_ack) begin
      expected_block_next = done ? 16'd1 : expected_block + 16'd1;
    end
  end

  assign block_minus_one = block_seen_next - 16'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_index   <= '0;
      opcode_seen    <= '0;
      block_seen     <= '0;
      expected_block <= 16'd1;
      payload_count  <= '0;
    end else if (accept) begin
      expected_block <= expected_block_next;
      if (rx.packet_end) begin
        header_index  <= '0;
        opcode_seen   <= '0;
        block_seen    <= '0;
        payload_count <= '0;
      end else begin
        header_index  <= header_index_next;
        opcode_seen   <= opcode_seen_next;
        block_seen    <= block_seen_next;
        payload_count <= payload_count_next;
      end
    end
  end

  // block start offset, ready before the first payload byte
  always_ff @(posedge clk) begin
    if (accept && header_index == HDR_LAST) begin
      block_offset <= 32'(block_minus_one) * BLOCK_MUL;
    end
  end

  always_comb begin
    work_valid     = accept && (has_write || has_ack);
    work.has_write = has_write;
    work.has_ack   = has_ack;
    work.offset    = block_offset + 32'(payload_count);
    work.data      = rx.payload_byte;
    work.block     = block_seen_next;
    work.port      = rx.peer_port;
    work.done      = done;
  end

endmodule

// ===== design/tdbr_queue.sv =====
module tdbr_queue
  import tdbr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  work_t push_item,
  input  logic  push,
  output logic  push_ready,
  output work_t head,
  output logic  head_valid,
  input  logic  pop
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [NW-1:0] FULL_COUNT = NW'(QUEUE_DEPTH);

  work_t         slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [NW-1:0] count;
  logic          do_push, do_pop;

  assign push_ready = count != FULL_COUNT;
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + NW'(do_push) - NW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== design/tdbr_back.sv =====
module tdbr_back
  import tdbr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic [31:0]   load_base,
  input  work_t         head,
  input  logic          head_valid,
  output logic          pop,
  tdbr_result_if.source results
);

  logic phase;
  logic load, emit_write;

  assign load       = !results.valid || results.ready;
  assign emit_write = head.has_write && !phase;
  // a write followed by an ack stays at the head for a second transfer
  assign pop        = load && head_valid && !(emit_write && head.has_ack);

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
      phase         <= 1'b0;
    end else if (load) begin
      results.valid <= head_valid;
      if (head_valid) begin
        phase <= emit_write && head.has_ack;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      if (emit_write) begin
        results.result_kind   <= KIND_WRITE;
        results.write_address <= load_base + head.offset;
        results.write_data    <= head.data;
        results.ack_block     <= '0;
        results.ack_port      <= '0;
        results.transfer_done <= 1'b0;
        results.last_of_run   <= !head.has_ack;
      end else begin
        results.result_kind   <= KIND_ACK;
        results.write_address <= '0;
        results.write_data    <= '0;
        results.ack_block     <= head.block;
        results.ack_port      <= head.port;
        results.transfer_done <= head.done;
        results.last_of_run   <= 1'b1;
      end
    end
  end

endmodule

// ===== sim/tftp_data_block_receiver_core_tb.sv =====
module tftp_data_block_receiver_core_tb;
  import tdbr_pkg::*;

  localparam int          BLOCK_BYTES = 512;
  localparam logic [15:0] OPCODE_ACK  = 16'd4;
  localparam int          ITEM_TARGET = 1850;

  typedef struct {
    result_kind_t kind;
    logic [31:0]  addr;
    logic [7:0]   data;
    logic [15:0]  blk;
    logic [15:0]  port;
    logic         done;
    logic         last;
  } tftp_result_t;

  logic        clk;
  logic        rst;
  logic        cfg_write_en;
  logic [31:0] cfg_write_data;

  tdbr_byte_if   rx_if ();
  tdbr_result_if res_if ();

  tftp_data_block_receiver_core #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .rx            (rx_if),
    .results       (res_if)
  );

  // receive-side tracking of the download
  logic [31:0] load_base_now;
  int          hdr_count;
  logic [15:0] opcode_got;
  logic [15:0] block_got;
  logic [15:0] next_block;
  int          bytes_stored;

  tftp_result_t pending_results[$];

  int  items_sent;
  int  results_seen;
  int  acks_seen;
  int  done_acks_seen;
  int  config_writes;
  int  mismatches;
  bit  steady;
  int  hold_request;
  int  hold_left;

  always #5 clk = ~clk;

  task automatic predict_tftp_byte(input logic [7:0] b, input logic fin,
                                   input logic [15:0] port);
    tftp_result_t wr;
    tftp_result_t ack;
    bit           has_wr;
    bit           has_ack;
    logic [15:0]  blk_index;
    logic [31:0]  blk_offset;
    has_wr  = 0;
    has_ack = 0;
    if (hdr_count < 4) begin
      if (hdr_count < 2) opcode_got = {opcode_got[7:0], b};
      else block_got = {block_got[7:0], b};
      hdr_count++;
    end else if (opcode_got == OPCODE_DATA && block_got == next_block) begin
      if (bytes_stored < BLOCK_BYTES) begin
        blk_index  = block_got - 16'd1;
        blk_offset = {16'd0, blk_index} * 32'(BLOCK_BYTES);
        wr.kind = KIND_WRITE;
        wr.addr = load_base_now + blk_offset + 32'(bytes_stored);
        wr.data = b;
        wr.blk  = '0;
        wr.port = '0;
        wr.done = 1'b0;
        has_wr  = 1;
        bytes_stored++;
      end
    end
    if (fin) begin
      if (hdr_count >= 4 && opcode_got == OPCODE_DATA && block_got == next_block) begin
        ack.kind = KIND_ACK;
        ack.addr = '0;
        ack.data = '0;
        ack.blk  = block_got;
        ack.port = port;
        ack.done = bytes_stored < BLOCK_BYTES;
        ack.last = 1'b1;
        has_ack  = 1;
        next_block = ack.done ? 16'd1 : next_block + 16'd1;
      end
      hdr_count    = 0;
      opcode_got   = '0;
      block_got    = '0;
      bytes_stored = 0;
    end
    if (has_wr) begin
      wr.last = !has_ack;
      pending_results.push_back(wr);
    end
    if (has_ack) pending_results.push_back(ack);
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] want_val,
                               input logic [31:0] got_val);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h, got %h (result %0d)", what, want_val, got_val,
               results_seen);
  endtask

  task automatic check_field(input string what, input logic [31:0] want_val,
                             input logic [31:0] got_val);
    if (got_val !== want_val) flag_mismatch(what, want_val, got_val);
  endtask

  always @(posedge clk) begin
    tftp_result_t want;
    if (!rst && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      results_seen++;
      if (res_if.result_kind === KIND_ACK) begin
        acks_seen++;
        if (res_if.transfer_done === 1'b1) done_acks_seen++;
      end
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result", '0, res_if.write_address);
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", 32'(want.kind), 32'(res_if.result_kind));
        check_field("write_address", want.addr, res_if.write_address);
        check_field("write_data", 32'(want.data), 32'(res_if.write_data));
        check_field("ack_block", 32'(want.blk), 32'(res_if.ack_block));
        check_field("ack_port", 32'(want.port), 32'(res_if.ack_port));
        check_field("transfer_done", 32'(want.done), 32'(res_if.transfer_done));
        check_field("last_of_run", 32'(want.last), 32'(res_if.last_of_run));
      end
    end
  end

  // result side: random back-pressure, plus a counted hold-off on request
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= steady || ($urandom_range(0, 99) >= 25);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin, input logic [15:0] port);
    while (!steady && $urandom_range(0, 99) < 25) begin
      @(negedge clk);
      rx_if.valid <= 1'b0;
    end
    @(negedge clk);
    rx_if.valid        <= 1'b1;
    rx_if.payload_byte <= b;
    rx_if.packet_end   <= fin;
    rx_if.peer_port    <= port;
    do @(posedge clk); while (rx_if.ready !== 1'b1);
    predict_tftp_byte(b, fin, port);
    items_sent++;
  endtask

  task automatic send_data_packet(input logic [15:0] opcode, input logic [15:0] blk,
                                  input int len, input logic [15:0] port);
    send_byte(opcode[15:8], 1'b0, port);
    send_byte(opcode[7:0], 1'b0, port);
    send_byte(blk[15:8], 1'b0, port);
    send_byte(blk[7:0], len == 0, port);
    for (int i = 0; i < len; i++) send_byte(8'($urandom), i == len - 1, port);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    @(negedge clk);
    rx_if.valid <= 1'b0;
    while (pending_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_results.size() != 0) begin
      flag_mismatch("results still outstanding", '0, pending_results.size());
      pending_results.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_load_base(input logic [31:0] value);
    wait_drained();
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
    load_base_now = value;
    config_writes++;
  endtask

  task automatic send_random_packet();
    int          pick;
    int          len;
    logic [15:0] port;
    logic [15:0] op;
    logic [15:0] blk;
    pick = $urandom_range(0, 99);
    port = 16'($urandom);
    if (pick < 65) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 60) : $urandom_range(0, 24);
      send_data_packet(OPCODE_DATA, next_block, len, port);
    end else if (pick < 75) begin
      blk = 16'($urandom);
      if (blk == next_block) blk = ~blk;
      send_data_packet(OPCODE_DATA, blk, $urandom_range(0, 8), port);
    end else if (pick < 85) begin
      op = $urandom_range(0, 1) ? OPCODE_ACK : 16'($urandom);
      if (op == OPCODE_DATA) op = OPCODE_ACK;
      send_data_packet(op, next_block, $urandom_range(0, 8), port);
    end else if (pick < 95) begin
      len = $urandom_range(1, 3);
      for (int i = 0; i < len; i++) send_byte(8'($urandom), i == len - 1, port);
    end else begin
      // garbage that may leave a packet half open
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        send_byte(8'($urandom), $urandom_range(0, 3) == 0, port);
      end
    end
  endtask

  task automatic test_directed_cases();
    send_byte(8'hFF, 1'b1, 16'h0000);
    send_byte(8'h00, 1'b0, 16'h0000);
    send_byte(8'h03, 1'b0, 16'h0000);
    send_byte(8'h00, 1'b1, 16'h0000);
    send_data_packet(16'hFFFF, 16'd1, 1, 16'h0000);
    send_data_packet(OPCODE_DATA, 16'd2, 1, 16'h0000);
    send_data_packet(OPCODE_DATA, 16'd1, 0, 16'h0000);
    send_byte(8'h00, 1'b0, 16'hFFFF);
    send_byte(8'h03, 1'b0, 16'hFFFF);
    send_byte(8'h00, 1'b0, 16'hFFFF);
    send_byte(8'h01, 1'b0, 16'hFFFF);
    send_byte(8'h00, 1'b0, 16'hFFFF);
    send_byte(8'hFF, 1'b1, 16'hFFFF);
    wait_drained();
  endtask

  task automatic test_address_wrap();
    write_load_base(32'hFFFF_FE00);
    // oversized full block at full rate, then a short block across address zero
    steady = 1;
    send_data_packet(OPCODE_DATA, 16'd1, BLOCK_BYTES + 4, 16'($urandom));
    steady = 0;
    send_data_packet(OPCODE_DATA, 16'd2, BLOCK_BYTES - 1, 16'($urandom));
    write_load_base(32'hFFFF_FFFF);
    send_data_packet(OPCODE_DATA, 16'd1, 3, 16'($urandom));
    wait_drained();
  endtask

  task automatic test_output_hold();
    hold_request = 300;
    send_data_packet(OPCODE_DATA, next_block, 30, 16'($urandom));
    send_data_packet(OPCODE_DATA, next_block, 2, 16'($urandom));
    wait_drained();
  endtask

  task automatic test_random_traffic(input logic [31:0] base, input int stop_at);
    write_load_base(base);
    while (items_sent < stop_at) begin
      send_random_packet();
      if ($urandom_range(0, 99) < 5) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    cfg_write_en   = 1'b0;
    cfg_write_data = '0;
    rx_if.valid        = 1'b0;
    rx_if.payload_byte = '0;
    rx_if.packet_end   = 1'b0;
    rx_if.peer_port    = '0;
    res_if.ready       = 1'b0;
    load_base_now = LOAD_BASE_RESET;
    hdr_count     = 0;
    opcode_got    = '0;
    block_got     = '0;
    next_block    = 16'd1;
    bytes_stored  = 0;
    items_sent     = 0;
    results_seen   = 0;
    acks_seen      = 0;
    done_acks_seen = 0;
    config_writes  = 0;
    mismatches     = 0;
    steady         = 0;
    hold_request   = 0;
    hold_left      = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_address_wrap();
    test_output_hold();
    test_random_traffic(32'h0000_0000, ITEM_TARGET - 600);
    test_random_traffic($urandom, ITEM_TARGET - 300);
    test_random_traffic(LOAD_BASE_RESET, ITEM_TARGET);
    repeat (10) @(posedge clk);

    $display("covered %0d byte transfers and %0d results, %0d acks (%0d final)",
             items_sent, results_seen, acks_seen, done_acks_seen);
    $display("load base written %0d times, address wrap and oversized block included",
             config_writes);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
